/* rtl/flash_erase_planner_macros.svh */
// Assertion helpers for the erase planner. All checks run on clk_i and are
// silent while rst_ni is low.
`ifndef FLASH_ERASE_PLANNER_MACROS_SVH
`define FLASH_ERASE_PLANNER_MACROS_SVH

// A condition that must hold at every clock edge.
`define FEP_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed: name");

// A consequence that must hold in the cycle after its trigger.
`define FEP_ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("assertion failed: name");

`endif

/* rtl/fep_pkg.sv */
package fep_pkg;

  // Highest byte address plus one that a request may reach is 2**AddrBits.
  localparam int unsigned AddrBits = 32;

  localparam logic [32:0] BlockSize     = 33'h0_0001_0000;
  localparam logic [32:0] SectorSize    = 33'h0_0000_1000;
  localparam logic [32:0] FixedChipSize = 33'h0_0040_0000;
  localparam logic [32:0] AddrLimit     = 33'(1) << AddrBits;

  localparam logic [1:0] ModeBoth       = 2'd0;
  localparam logic [1:0] ModeBlockOnly  = 2'd1;
  localparam logic [1:0] ModeEdgeSector = 2'd2;

  localparam logic CfgDeviceMode = 1'b0;
  localparam logic CfgChipSize   = 1'b1;

  localparam logic CmdStart   = 1'b0;
  localparam logic CmdAdvance = 1'b1;

  typedef enum logic [2:0] {
    ActSector = 3'd0,
    ActBlock  = 3'd1,
    ActDone   = 3'd2,
    ActReject = 3'd3,
    ActShort  = 3'd4,
    ActIdle   = 3'd5
  } action_e;

  typedef struct packed {
    logic        command;
    logic [31:0] start_address;
    logic [31:0] min_length;
    logic [31:0] allowed_length;
  } req_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] erase_address;
  } res_t;

  typedef struct packed {
    logic        busy;
    logic [32:0] next_address;
    logic [32:0] remaining_allowed;
    logic [32:0] finish_address;
  } state_t;

  typedef struct packed {
    logic [1:0]  device_mode;
    logic [31:0] flash_size;
  } cfg_t;

endpackage

/* rtl/fep_chan_if.sv */
interface fep_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/fep_core.sv */
// Decision logic for one request: checks a start, picks the next erase and
// computes the state that follows.
module fep_core #(
  parameter int unsigned AddrBits = fep_pkg::AddrBits
) (
  input  fep_pkg::cfg_t   cfg_i,
  input  fep_pkg::req_t   req_i,
  input  fep_pkg::state_t st_i,
  output fep_pkg::state_t st_o,
  output fep_pkg::res_t   res_o
);

  localparam logic [32:0] AddrLimit = 33'(1) << AddrBits;

  logic [32:0] addr, req_len, allow, unit_mask, need, span, chip;
  logic [32:0] a, ra;
  logic        is_start, misaligned, out_of_chip, reject;
  logic        below, at_edge, use_sector;

  assign is_start  = (req_i.command == fep_pkg::CmdStart);
  assign addr      = {1'b0, req_i.start_address};
  assign req_len   = {1'b0, req_i.min_length};
  assign allow     = {1'b0, req_i.allowed_length};
  assign unit_mask = (cfg_i.device_mode == fep_pkg::ModeBlockOnly) ?
                     (fep_pkg::BlockSize - 33'd1) : (fep_pkg::SectorSize - 33'd1);
  assign need      = (req_len + unit_mask) & ~unit_mask;
  assign span      = addr + allow;
  assign chip      = (cfg_i.device_mode == fep_pkg::ModeEdgeSector) ?
                     fep_pkg::FixedChipSize : {1'b0, cfg_i.flash_size};

  assign misaligned  = (|(addr & unit_mask)) || (|(allow & unit_mask));
  assign out_of_chip = (chip != 33'd0) && ((addr >= chip) || (span > chip));
  assign reject      = misaligned || out_of_chip || (span > AddrLimit) ||
                       (allow < need);

  // On a start the first step runs on the freshly loaded values; the finish
  // address lies beyond the start exactly when the required length is nonzero.
  assign a     = is_start ? addr : st_i.next_address;
  assign ra    = is_start ? allow : st_i.remaining_allowed;
  assign below = is_start ? (req_len != 33'd0) :
                 (st_i.next_address < st_i.finish_address);

  // The edge mode only ever uses the fixed 4MB chip size.
  assign at_edge    = (cfg_i.device_mode == fep_pkg::ModeEdgeSector) &&
                      ((a < fep_pkg::BlockSize) ||
                       (a >= (fep_pkg::FixedChipSize - fep_pkg::BlockSize)));
  assign use_sector = (cfg_i.device_mode != fep_pkg::ModeBlockOnly) &&
                      ((ra < fep_pkg::BlockSize) || (|a[15:0]) || at_edge);

  always_comb begin
    st_o               = st_i;
    res_o.action       = fep_pkg::ActIdle;
    res_o.erase_address = '0;
    if (is_start && reject) begin
      st_o.busy    = 1'b0;
      res_o.action = fep_pkg::ActReject;
    end else if (is_start || st_i.busy) begin
      if (is_start) begin
        st_o.next_address      = addr;
        st_o.remaining_allowed = allow;
        st_o.finish_address    = addr + req_len;
        st_o.busy              = 1'b1;
      end
      if (below && (ra >= fep_pkg::SectorSize)) begin
        if (use_sector) begin
          st_o.next_address      = a + fep_pkg::SectorSize;
          st_o.remaining_allowed = ra - fep_pkg::SectorSize;
          res_o.action           = fep_pkg::ActSector;
          res_o.erase_address    = a[31:0];
        end else if (ra >= fep_pkg::BlockSize) begin
          st_o.next_address      = a + fep_pkg::BlockSize;
          st_o.remaining_allowed = ra - fep_pkg::BlockSize;
          res_o.action           = fep_pkg::ActBlock;
          res_o.erase_address    = a[31:0];
        end else begin
          st_o.busy    = 1'b0;
          res_o.action = fep_pkg::ActShort;
        end
      end else begin
        st_o.busy    = 1'b0;
        res_o.action = below ? fep_pkg::ActShort : fep_pkg::ActDone;
      end
    end
  end

endmodule

/* rtl/flash_erase_planner.sv */
// Channel  Dir  Payload                                             Accepted when
// in_if    in   command, start_address, min_length,                 valid && ready
//               allowed_length
// out_if   out  action, erase_address                               valid && ready
// cfg      in   cfg_idx_i selects the register, cfg_wdata_i value   cfg_we_i high
//
// Every request is decided at the edge that accepts it, and
// its result sits in the output register from the next cycle on.
// One request per cycle is sustained while out_if.ready stays high; the only loop
// is the request state, updated in that same cycle.
// A stalled result blocks the input only while the output register stays full
// and unread. Reset (rst_ni low, asynchronous) clears the request state and
// both registers; mode and chip size return to zero.
module flash_erase_planner #(
  parameter int unsigned AddrBits = fep_pkg::AddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  fep_chan_if.sink    in_if,
  fep_chan_if.source  out_if
);

`include "flash_erase_planner_macros.svh"

  fep_pkg::cfg_t   cfg_q;
  fep_pkg::state_t st_q, st_d;
  fep_pkg::res_t   res_q, res_d;
  logic            out_valid_q;
  logic            in_fire;

  assign in_if.ready    = !out_valid_q || out_if.ready;
  assign in_fire        = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = res_q;

  fep_core #(
    .AddrBits (AddrBits)
  ) u_core (
    .cfg_i (cfg_q),
    .req_i (in_if.payload),
    .st_i  (st_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fep_pkg::CfgDeviceMode: cfg_q.device_mode <= cfg_wdata_i[1:0];
        fep_pkg::CfgChipSize:   cfg_q.flash_size  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q        <= st_d;
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `FEP_ASSERT_NEXT(idle_advance_a, in_fire && (in_if.payload.command == fep_pkg::CmdAdvance) && !st_q.busy, out_valid_q && (res_q.action == fep_pkg::ActIdle))
  `FEP_ASSERT_NEXT(erase_keeps_busy_a, in_fire && ((res_d.action == fep_pkg::ActSector) || (res_d.action == fep_pkg::ActBlock)), st_q.busy)
  `FEP_ASSERT(addr_zero_a, !out_valid_q || (res_q.action == fep_pkg::ActSector) || (res_q.action == fep_pkg::ActBlock) || (res_q.erase_address == 32'd0))
  `FEP_ASSERT(next_aligned_a, !st_q.busy || (st_q.next_address[11:0] == 12'd0))

endmodule
